FILE: design/zsbf_pkg.sv
`default_nettype none
package zsbf_pkg;

  // default sizing
  localparam int BLOCK_MAX_DEF   = 65535;
  localparam int LENGTH_BITS_DEF = 32;

  // request commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // zlib stream constants
  localparam logic [7:0]  ZLIB_CMF       = 8'h78;
  localparam logic [7:0]  ZLIB_FLG       = 8'h01;
  localparam logic [16:0] ADLER_MOD      = 17'd65521;
  // zlib header (2) + one block header (5) + trailer (4)
  localparam int          FRAME_OVERHEAD = 11;

  // framer sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVIDE,
    S_QUOT,
    S_BOUND,
    S_CHECK,
    S_ZHDR1,
    S_BH0,
    S_BH1,
    S_BH2,
    S_BH3,
    S_BH4,
    S_TR0,
    S_TR1,
    S_TR2,
    S_TR3
  } state_t;

endpackage
`default_nettype wire

FILE: design/zlib_stored_block_framer.sv
// zlib framer for stored (uncompressed) deflate blocks with an Adler-32 trailer. A start
// request (command 0) carries the message length and the output capacity; the capacity is
// checked against length + 5 bytes per BLOCK_MAX-byte block + 6, and a short capacity gives a
// single error result. An accepted start yields eleven results for an empty message and
// seven otherwise (zlib header and first block header); its first result passes the input
// register, the low and high halves of the reciprocal multiply giving length / BLOCK_MAX, the
// bound sum and the check, and the request channel is held off until that check. A data
// request (command 1) is echoed via the input and result registers; requests stream back to
// back at one per cycle while the output is ready and no header or trailer is due. The byte
// that closes a block adds five header bytes, the last byte the four Adler-32 bytes, one result
// per cycle while the output is ready. Data requests with no active message give no result.
`default_nettype none
module zlib_stored_block_framer
  import zsbf_pkg::*;
#(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] total_length,
  input  wire logic [32:0] capacity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic             message_end,
  output logic             error,
  output logic [32:0]      total_size
);

  localparam int LB     = LENGTH_BITS;
  localparam int CMP_W  = (LB + 4 > 33) ? LB + 4 : 33;
  localparam int W2     = (LB > 16) ? LB : 16;
  localparam int HL     = LB / 2;
  localparam int HH     = LB - HL;
  localparam int PW     = 2 * LB + 1;
  localparam int MW     = LB + 1;
  localparam int RS     = LB + $clog2(BLOCK_MAX);
  localparam logic [16:0]      BLK_MAX17 = 17'(BLOCK_MAX);
  localparam logic [15:0]      BLK_MAX16 = 16'(BLOCK_MAX);
  localparam logic [W2-1:0]    BLK_MAXW  = W2'(BLOCK_MAX);
  // ceil(2^RS / BLOCK_MAX), exact quotient for every LB-bit length
  localparam logic [LB:0]      RECIP     =
    MW'(((128'd1 << RS) + 128'(BLOCK_MAX) - 128'd1) / 128'(BLOCK_MAX));

  // framer state
  state_t          state;
  state_t          state_next;
  logic [15:0]     sum_low;
  logic [15:0]     sum_high;
  logic [LB-1:0]   bytes_remaining;
  logic [15:0]     block_remaining;
  logic [32:0]     bytes_emitted;
  logic            message_active;

  // input register
  logic            ir_valid;
  logic            ir_command;
  logic [7:0]      ir_byte;
  logic [LB-1:0]   ir_length;
  logic [32:0]     ir_capacity;
  logic            ir_consume;

  // quotient and bound
  logic [HL+LB:0]  prod_lo;
  logic [HH+LB:0]  prod_hi;
  logic [PW-1:0]   prod_sum;
  logic [LB-1:0]   div_quo;
  logic [CMP_W-1:0] bound;
  logic            reject;

  // per-cycle result
  logic            slot_free;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_end;
  logic            emit_error;
  logic [32:0]     emitted_inc;

  // adler and counter updates for a data byte
  logic [16:0]     sl_sum;
  logic [15:0]     sl_new;
  logic [16:0]     sh_sum;
  logic [15:0]     sh_new;
  logic            rem_ends;
  logic            blk_ends;
  logic [W2-1:0]   rem_wide;
  logic            final_now;
  logic [15:0]     hdr_len;

  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = !ir_valid || ir_consume;
  assign emitted_inc = bytes_emitted + 33'd1;

  assign sl_sum = {1'b0, sum_low} + {9'd0, ir_byte};
  assign sl_new = (sl_sum >= ADLER_MOD) ? 16'(sl_sum - ADLER_MOD) : sl_sum[15:0];
  assign sh_sum = {1'b0, sum_high} + {1'b0, sl_new};
  assign sh_new = (sh_sum >= ADLER_MOD) ? 16'(sh_sum - ADLER_MOD) : sh_sum[15:0];

  assign rem_ends = (bytes_remaining <= LB'(1));
  assign blk_ends = (block_remaining <= 16'd1);

  // next block size and final flag
  assign rem_wide   = W2'(bytes_remaining);
  assign final_now  = (rem_wide <= BLK_MAXW);
  assign hdr_len    = final_now ? rem_wide[15:0] : BLK_MAX16;

  // high half of the reciprocal product, folded with the registered low half
  assign prod_hi  = {{(LB+1){1'b0}}, ir_length[LB-1:HL]} * {{HH{1'b0}}, RECIP};
  assign prod_sum = PW'(prod_lo) + (PW'(prod_hi) << HL);

  assign reject = (CMP_W'(ir_capacity) < bound);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ir_valid) begin
          if (ir_command == CMD_START) begin
            state_next = S_DIVIDE;
          end else if (message_active && slot_free) begin
            if (rem_ends) begin
              state_next = S_TR0;
            end else if (blk_ends) begin
              state_next = S_BH0;
            end
          end
        end
      end
      S_DIVIDE: state_next = S_QUOT;
      S_QUOT:   state_next = S_BOUND;
      S_BOUND:  state_next = S_CHECK;
      S_CHECK:  if (slot_free) state_next = reject ? S_IDLE : S_ZHDR1;
      S_ZHDR1:  if (slot_free) state_next = S_BH0;
      S_BH0:    if (slot_free) state_next = S_BH1;
      S_BH1:    if (slot_free) state_next = S_BH2;
      S_BH2:    if (slot_free) state_next = S_BH3;
      S_BH3:    if (slot_free) state_next = S_BH4;
      S_BH4: begin
        if (slot_free) state_next = (bytes_remaining == '0) ? S_TR0 : S_IDLE;
      end
      S_TR0:    if (slot_free) state_next = S_TR1;
      S_TR1:    if (slot_free) state_next = S_TR2;
      S_TR2:    if (slot_free) state_next = S_TR3;
      S_TR3:    if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // result selection and input consumption
  always_comb begin
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_end   = 1'b0;
    emit_error = 1'b0;
    ir_consume = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (ir_valid && ir_command == CMD_DATA) begin
          ir_consume = !message_active || slot_free;
          emit       = message_active && slot_free;
          emit_byte  = ir_byte;
        end
      end
      S_DIVIDE, S_QUOT, S_BOUND: begin
        emit = 1'b0;
      end
      S_CHECK: begin
        ir_consume = slot_free;
        emit       = slot_free;
        emit_error = reject;
        emit_byte  = reject ? 8'd0 : ZLIB_CMF;
      end
      S_ZHDR1: begin
        emit      = slot_free;
        emit_byte = ZLIB_FLG;
      end
      S_BH0: begin
        emit      = slot_free;
        emit_byte = {7'd0, final_now};
      end
      S_BH1: begin
        emit      = slot_free;
        emit_byte = block_remaining[7:0];
      end
      S_BH2: begin
        emit      = slot_free;
        emit_byte = block_remaining[15:8];
      end
      S_BH3: begin
        emit      = slot_free;
        emit_byte = ~block_remaining[7:0];
      end
      S_BH4: begin
        emit      = slot_free;
        emit_byte = ~block_remaining[15:8];
      end
      S_TR0: begin
        emit      = slot_free;
        emit_byte = sum_high[15:8];
      end
      S_TR1: begin
        emit      = slot_free;
        emit_byte = sum_high[7:0];
      end
      S_TR2: begin
        emit      = slot_free;
        emit_byte = sum_low[15:8];
      end
      S_TR3: begin
        emit      = slot_free;
        emit_byte = sum_low[7:0];
        emit_end  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ir_valid <= 1'b1;
    end else if (ir_consume) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_command  <= command;
      ir_byte     <= data_byte;
      ir_length   <= LB'(total_length);
      ir_capacity <= capacity;
    end
  end

  // length / BLOCK_MAX by reciprocal multiply, low half then high half
  always_ff @(posedge clk) begin
    if (state == S_DIVIDE) begin
      prod_lo <= {{(LB+1){1'b0}}, ir_length[HL-1:0]} * {{HL{1'b0}}, RECIP};
    end
    if (state == S_QUOT) begin
      div_quo <= LB'(prod_sum >> RS);
    end
  end

  // size bound
  always_ff @(posedge clk) begin
    if (state == S_BOUND) begin
      bound <= CMP_W'(ir_length) + (CMP_W'(div_quo) << 2) + CMP_W'(div_quo)
             + CMP_W'(FRAME_OVERHEAD);
    end
  end

  // sequencer and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sum_low         <= 16'd1;
      sum_high        <= 16'd0;
      bytes_remaining <= '0;
      block_remaining <= 16'd0;
      bytes_emitted   <= 33'd0;
      message_active  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        bytes_emitted <= (state == S_CHECK) ? (reject ? 33'd0 : 33'd1) : emitted_inc;
        unique case (state)
          S_IDLE: begin
            sum_low         <= sl_new;
            sum_high        <= sh_new;
            if (bytes_remaining != '0) bytes_remaining <= bytes_remaining - LB'(1);
            if (block_remaining != 16'd0) block_remaining <= block_remaining - 16'd1;
          end
          S_CHECK: begin
            sum_low         <= 16'd1;
            sum_high        <= 16'd0;
            block_remaining <= 16'd0;
            message_active  <= !reject;
            bytes_remaining <= reject ? '0 : ir_length;
          end
          S_BH0: begin
            block_remaining <= hdr_len;
          end
          S_TR3: begin
            message_active <= 1'b0;
          end
          default: begin
            message_active <= message_active;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      out_byte    <= emit_byte;
      last        <= (state_next == S_IDLE);
      message_end <= emit_end;
      error       <= emit_error;
      total_size  <= emit_end ? emitted_inc : 33'd0;
    end
  end

`ifndef SYNTHESIS
  // a rejected start gives exactly one result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && !message_end)
    else $error("error result not marked last");

  // the stream ends on the final result of a request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> last && !error)
    else $error("message end not on last result");

  // a message closes only by its trailer or by a new start
  assert property (@(posedge clk) disable iff (rst)
    $fell(message_active) |-> $past(state == S_TR3 || state == S_CHECK))
    else $error("message dropped outside trailer or start");

  // adler sums stay reduced
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, sum_low} < ADLER_MOD && {1'b0, sum_high} < ADLER_MOD)
    else $error("adler sum out of range");

  // block byte count never exceeds one block
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, block_remaining} <= BLK_MAX17)
    else $error("block count above block size");
`endif

endmodule
`default_nettype wire

FILE: dv/zsbf_stream_check.sv
`timescale 1ns / 100ps
module zsbf_stream_check
  import zsbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] total_length,
  input  wire logic [32:0] capacity,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  out_byte,
  input  wire logic        last,
  input  wire logic        message_end,
  input  wire logic        error,
  input  wire logic [32:0] total_size,
  output int               fail_count,
  output int               pending
);

  // one byte of the framed stream as it leaves the block
  typedef struct packed {
    logic [7:0]  octet;
    logic        fin;
    logic        msg_end;
    logic        err;
    logic [32:0] size;
  } zres_t;

  localparam logic [31:0] BLK = BLOCK_MAX_DEF;
  localparam logic [16:0] MOD = ADLER_MOD;

  zres_t       expected_stream[$];

  // framer state as predicted
  logic [16:0] adler_a;
  logic [16:0] adler_b;
  logic [31:0] left_total;
  logic [15:0] left_block;
  logic [32:0] written;
  logic        active;

  // append one stream byte, the trailer end carries the running size
  task automatic push_octet(input logic [7:0] v, input logic done);
    zres_t r;
    written = written + 33'd1;
    r = '0;
    r.octet = v;
    r.msg_end = done;
    r.size = done ? written : 33'd0;
    expected_stream.push_back(r);
  endtask

  // stored block header: final flag, LEN and NLEN little-endian
  task automatic push_block_hdr();
    logic [15:0] blen;
    logic [15:0] nlen;
    blen = (left_total > BLK) ? BLK[15:0] : left_total[15:0];
    nlen = ~blen;
    push_octet((left_total <= BLK) ? 8'h01 : 8'h00, 1'b0);
    push_octet(blen[7:0], 1'b0);
    push_octet(blen[15:8], 1'b0);
    push_octet(nlen[7:0], 1'b0);
    push_octet(nlen[15:8], 1'b0);
    left_block = blen;
  endtask

  // big-endian adler-32 closes the stream
  task automatic push_trailer();
    push_octet(adler_b[15:8], 1'b0);
    push_octet(adler_b[7:0], 1'b0);
    push_octet(adler_a[15:8], 1'b0);
    push_octet(adler_a[7:0], 1'b1);
    active = 1'b0;
  endtask

  // work out every byte caused by one accepted request
  task automatic predict_request();
    logic [33:0] bound;
    int          prior_count;
    zres_t       r;
    prior_count = expected_stream.size();
    if (command == CMD_START) begin
      bound = 34'(total_length) + 34'((total_length / BLK + 32'd1) * 32'd5) + 34'd6;
      adler_a = 17'd1;
      adler_b = 17'd0;
      written = 33'd0;
      left_block = 16'd0;
      if ({1'b0, capacity} < bound) begin
        active = 1'b0;
        left_total = 32'd0;
        r = '0;
        r.err = 1'b1;
        expected_stream.push_back(r);
      end else begin
        active = 1'b1;
        left_total = total_length;
        push_octet(ZLIB_CMF, 1'b0);
        push_octet(ZLIB_FLG, 1'b0);
        push_block_hdr();
        if (total_length == 32'd0) push_trailer();
      end
    end else if (active) begin
      push_octet(data_byte, 1'b0);
      adler_a = adler_a + 17'(data_byte);
      if (adler_a >= MOD) adler_a = adler_a - MOD;
      adler_b = adler_b + adler_a;
      if (adler_b >= MOD) adler_b = adler_b - MOD;
      if (left_total != 32'd0) left_total = left_total - 32'd1;
      if (left_block != 16'd0) left_block = left_block - 16'd1;
      if (left_total == 32'd0) push_trailer();
      else if (left_block == 16'd0) push_block_hdr();
    end
    // mark the final byte of this request
    if (expected_stream.size() > prior_count) begin
      r = expected_stream.pop_back();
      r.fin = 1'b1;
      expected_stream.push_back(r);
    end
  endtask

  // compare one accepted result with the oldest expected byte
  task automatic check_result();
    zres_t want;
    zres_t got;
    got = {out_byte, last, message_end, error, total_size};
    if (expected_stream.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: byte %02h last %0d end %0d err %0d size %0d",
                 got.octet, got.fin, got.msg_end, got.err, got.size);
    end else begin
      want = expected_stream.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected byte %02h last %0d end %0d err %0d size %0d, %s",
                   want.octet, want.fin, want.msg_end, want.err, want.size,
                   $sformatf("got byte %02h last %0d end %0d err %0d size %0d",
                             got.octet, got.fin, got.msg_end, got.err, got.size));
      end
    end
  endtask

  // requests are predicted before results are compared in the same edge
  always @(posedge clk) begin
    if (rst) begin
      adler_a = 17'd1;
      adler_b = 17'd0;
      left_total = 32'd0;
      left_block = 16'd0;
      written = 33'd0;
      active = 1'b0;
      expected_stream.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict_request();
      if (out_valid && out_ready) check_result();
    end
    pending = expected_stream.size();
  end

endmodule

FILE: dv/zlib_stored_block_framer_tb.sv
`timescale 1ns / 100ps
module zlib_stored_block_framer_tb;
  import zsbf_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [7:0]  data_byte;
  logic [31:0] total_length;
  logic [32:0] capacity;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last;
  logic        message_end;
  logic        error;
  logic [32:0] total_size;
  int          fail_count;
  int          pending;

  int          tx_gap_max = 16;
  int          rx_gap_max = 16;
  int          hold_cycles = 0;

  zlib_stored_block_framer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_byte    (data_byte),
    .total_length (total_length),
    .capacity     (capacity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last         (last),
    .message_end  (message_end),
    .error        (error),
    .total_size   (total_size)
  );

  zsbf_stream_check u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_byte    (data_byte),
    .total_length (total_length),
    .capacity     (capacity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last         (last),
    .message_end  (message_end),
    .error        (error),
    .total_size   (total_size),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("zlib_stored_block_framer verification failed");
    $finish;
  end

  // smallest capacity that a start of this length needs
  function automatic logic [33:0] stream_bound(input logic [31:0] len);
    return 34'(len) + 34'((len / 32'd65535 + 32'd1) * 32'd5) + 34'd6;
  endfunction

  // offer one request after a random gap and wait for its acceptance
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic [31:0] len,
                           input logic [32:0] cap);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= b;
    total_length <= len;
    capacity <= cap;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_start(input logic [31:0] len, input logic [32:0] cap);
    send_item(CMD_START, 8'($urandom_range(0, 255)), len, cap);
  endtask

  // unused start fields are kept random so their bits toggle
  task automatic send_data(input logic [7:0] b);
    send_item(CMD_DATA, b, $urandom, {1'($urandom_range(0, 1)), $urandom});
  endtask

  task automatic send_message(input logic [31:0] len, input logic [32:0] cap, input int nbytes);
    send_start(len, cap);
    repeat (nbytes) send_data(8'($urandom_range(0, 255)));
  endtask

  // hold the request channel idle until every expected byte is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // result side: random stall per result, plus an occasional long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [33:0] bnd;
    logic [31:0] len;
    logic [32:0] cap;
    int          random_items;
    int          pick;
    int          nbytes;
    bit          pressure_done;

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_START;
    data_byte = 8'h00;
    total_length = 32'd0;
    capacity = 33'd0;
    random_items = 0;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty message at exactly its bound, then one short of it
    send_start(32'd0, 33'd11);
    send_start(32'd0, 33'd10);
    // data with no active message is dropped
    send_data(8'h3c);
    // short message with extreme byte values
    send_start(32'd3, 33'd14);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h80);
    // largest length and capacity, then the bound edges of the largest length
    send_start(32'hffff_ffff, 33'h1_ffff_ffff);
    bnd = stream_bound(32'hffff_ffff);
    send_start(32'hffff_ffff, 33'(bnd - 34'd1));
    send_start(32'hffff_ffff, 33'(bnd));
    // exact multiple of the block size: the bound counts one block too many
    bnd = stream_bound(32'd131070);
    send_start(32'd131070, 33'(bnd - 34'd1));
    send_start(32'd131070, 33'(bnd));
    // restart while a message is in flight
    send_start(32'd5, 33'd16);
    send_data(8'ha5);
    send_data(8'h5a);
    send_start(32'd2, 33'd13);
    send_data(8'hff);
    send_data(8'h01);
    // byte past the end of a finished message
    send_data(8'h77);
    drain();

    // random traffic, mostly well-formed messages
    while (random_items < 250) begin
      if ($urandom_range(0, 9) == 0) tx_gap_max = $urandom_range(0, 1) ? 16 : 0;
      if ($urandom_range(0, 9) == 0) rx_gap_max = $urandom_range(0, 1) ? 16 : 0;

      // back-pressure: stall results while requests keep coming, then pause
      if (!pressure_done && random_items >= 120) begin
        pick = tx_gap_max;
        tx_gap_max = 0;
        hold_cycles = 300;
        send_message(32'd40, 33'(stream_bound(32'd40)), 40);
        drain();
        tx_gap_max = pick;
        random_items += 41;
        pressure_done = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // complete message
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        case ($urandom_range(0, 3))
          0: cap = 33'(stream_bound(len));
          1: cap = 33'h1_ffff_ffff;
          default: cap = 33'(stream_bound(len) + 34'($urandom_range(1, 5000)));
        endcase
        send_message(len, cap, len);
        random_items += len + 1;
      end else if (pick < 80) begin
        // message cut short, the next start abandons it
        len = $urandom_range(2, 12);
        nbytes = $urandom_range(0, len - 1);
        send_message(len, 33'(stream_bound(len)), nbytes);
        random_items += nbytes + 1;
      end else if (pick < 90) begin
        // full-range start fields
        send_start($urandom, {1'($urandom_range(0, 1)), $urandom});
        random_items += 1;
      end else begin
        // rejected start followed by stray bytes
        len = $urandom_range(0, 50);
        send_start(len, 33'($urandom_range(0, len + 10)));
        random_items += 1;
        repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)));
      end
    end

    // wait out every expected byte, then a margin for stray results
    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("zlib_stored_block_framer verification clean");
    end else begin
      $display("zlib_stored_block_framer verification failed");
    end
    $finish;
  end

endmodule
